[hdl/pnfd_pkg.sv]
// ----------------------------------------------------------------------------
// pnfd_pkg
// shared types and constants of the packed nucleotide to fasta decoder
// ----------------------------------------------------------------------------
package pnfd_pkg;

	localparam int RUN_MAX = 7;
	localparam int RUN_IW = $clog2(RUN_MAX);
	localparam int Q_DEPTH = 4;
	localparam int Q_AW = $clog2(Q_DEPTH);

	localparam logic [7:0] LINE_WIDTH_RST = 8'd70;
	localparam logic [7:0] MIN_WIDTH = 8'd4;

	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_C = 8'h43;
	localparam logic [7:0] CH_G = 8'h47;
	localparam logic [7:0] CH_T = 8'h54;
	localparam logic [7:0] CH_U = 8'h55;
	localparam logic [7:0] CH_NL = 8'h0a;

	typedef logic [7:0] char_t;

	// characters caused by one request, sent in order
	typedef struct packed {
		logic [RUN_MAX-1:0][7:0] chars;
		logic [RUN_IW-1:0] last_idx;
	} run_t;

endpackage

[hdl/pnfd_front.sv]
// ----------------------------------------------------------------------------
// pnfd_front
// parses the compressed stream and turns each request into a run of characters
// ----------------------------------------------------------------------------
module pnfd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         in_byte,
	input  logic [7:0]         line_width,
	output logic               push,
	output pnfd_pkg::run_t     run
);
	import pnfd_pkg::*;

	typedef enum logic [2:0] {
		PH_TYPE = 3'd0,
		PH_DLEN = 3'd1,
		PH_DESC = 3'd2,
		PH_SLEN = 3'd3,
		PH_DATA = 3'd4
	} phase_t;

	phase_t      phase_q, phase_d;
	logic        rna_q, rna_d;
	logic        pend_q, pend_d;
	logic [2:0]  fidx_q, fidx_d;
	logic [15:0] desc_q, desc_d;
	logic [63:0] acc_q, acc_d;
	logic [63:0] nuc_q, nuc_d;
	logic [7:0]  pos_q, pos_d;

	char_t       list [8];
	logic [3:0]  cnt;
	logic [7:0]  eff_w;
	logic [7:0]  pos;
	logic        ended;
	logic        end_hit;
	logic [1:0]  end_k;
	logic [1:0]  code;
	logic [15:0] dlen;
	logic [63:0] slen;

	assign eff_w = (line_width < MIN_WIDTH) ? MIN_WIDTH : line_width;
	assign end_hit = (nuc_q[63:3] == '0) && (nuc_q[2:0] <= 3'd4);
	assign end_k = nuc_q[1:0] - 2'd1;
	assign dlen = {in_byte, acc_q[7:0]};
	assign slen = {in_byte, acc_q[55:0]};

	always_comb begin
		phase_d = phase_q;
		rna_d = rna_q;
		pend_d = 1'b0;
		fidx_d = fidx_q;
		desc_d = desc_q;
		acc_d = acc_q;
		nuc_d = nuc_q;
		pos_d = pos_q;
		pos = pos_q;
		ended = 1'b0;
		code = '0;
		cnt = '0;
		for (int i = 0; i < 8; i++) begin
			list[i] = CH_NL;
		end
		if (pend_q) begin
			list[0] = CH_NL;
			cnt = 4'd1;
		end
		unique case (phase_q)
			PH_TYPE: begin
				rna_d = (in_byte != 8'd0);
				phase_d = PH_DLEN;
				fidx_d = '0;
				acc_d = '0;
			end
			PH_DLEN: begin
				if (fidx_q[0]) begin
					desc_d = dlen;
					fidx_d = '0;
					acc_d = '0;
					if (dlen == 16'd0) begin
						list[cnt[2:0]] = CH_NL;
						cnt = cnt + 4'd1;
						phase_d = PH_SLEN;
					end else begin
						phase_d = PH_DESC;
					end
				end else begin
					acc_d[7:0] = in_byte;
					fidx_d = 3'd1;
				end
			end
			PH_DESC: begin
				list[cnt[2:0]] = in_byte;
				cnt = cnt + 4'd1;
				desc_d = desc_q - 16'd1;
				if (desc_q == 16'd1) begin
					list[cnt[2:0]] = CH_NL;
					cnt = cnt + 4'd1;
					phase_d = PH_SLEN;
					fidx_d = '0;
					acc_d = '0;
				end
			end
			PH_SLEN: begin
				acc_d[fidx_q*8 +: 8] = in_byte;
				fidx_d = fidx_q + 3'd1;
				if (fidx_q == 3'd7) begin
					nuc_d = slen;
					pos_d = '0;
					if (slen == 64'd0) begin
						list[cnt[2:0]] = CH_NL;
						list[cnt[2:0] + 3'd1] = CH_NL;
						cnt = cnt + 4'd2;
						phase_d = PH_DLEN;
						fidx_d = '0;
						acc_d = '0;
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				for (int k = 0; k < 4; k++) begin
					if (!ended) begin
						code = 2'(in_byte >> (6 - 2 * k));
						case (code)
							2'd0: list[cnt[2:0]] = CH_A;
							2'd1: list[cnt[2:0]] = CH_C;
							2'd2: list[cnt[2:0]] = CH_G;
							default: list[cnt[2:0]] = rna_q ? CH_U : CH_T;
						endcase
						cnt = cnt + 4'd1;
						pos = pos + 8'd1;
						if (pos >= eff_w) begin
							list[cnt[2:0]] = CH_NL;
							cnt = cnt + 4'd1;
							pos = '0;
						end
						if (end_hit && (end_k == 2'(k))) begin
							if (pos != 8'd0) begin
								list[cnt[2:0]] = CH_NL;
								cnt = cnt + 4'd1;
							end
							pos = '0;
							list[cnt[2:0]] = CH_NL;
							cnt = cnt + 4'd1;
							if (cnt < 4'd8) begin
								list[cnt[2:0]] = CH_NL;
							end
							cnt = cnt + 4'd1;
							ended = 1'b1;
						end
					end
				end
				pos_d = pos;
				nuc_d = nuc_q - 64'd4;
				if (ended) begin
					phase_d = PH_DLEN;
					fidx_d = '0;
					acc_d = '0;
				end
			end
			default: begin
				phase_d = PH_TYPE;
			end
		endcase
		// an eighth character waits for the next request
		pend_d = (cnt == 4'd8);
	end

	always_comb begin
		for (int i = 0; i < RUN_MAX; i++) begin
			run.chars[i] = list[i];
		end
		run.last_idx = (cnt == 4'd8) ? RUN_IW'(RUN_MAX - 1) : RUN_IW'(cnt - 4'd1);
	end

	assign push = accept && (cnt != 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			rna_q <= 1'b0;
			pend_q <= 1'b0;
			fidx_q <= '0;
			desc_q <= '0;
			acc_q <= '0;
			nuc_q <= '0;
			pos_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			rna_q <= rna_d;
			pend_q <= pend_d;
			fidx_q <= fidx_d;
			desc_q <= desc_d;
			acc_q <= acc_d;
			nuc_q <= nuc_d;
			pos_q <= pos_d;
		end
	end

endmodule

[hdl/pnfd_queue.sv]
// ----------------------------------------------------------------------------
// pnfd_queue
// small fifo of character runs between the parser and the serializer
// ----------------------------------------------------------------------------
module pnfd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  pnfd_pkg::run_t     push_run,
	input  logic               pop,
	output pnfd_pkg::run_t     head,
	output logic               empty,
	output logic               full
);
	import pnfd_pkg::*;

	run_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q;
	logic [Q_AW-1:0] rd_q;
	logic [Q_AW:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_run;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
		end
	end

endmodule

[hdl/pnfd_back.sv]
// ----------------------------------------------------------------------------
// pnfd_back
// sends the characters of each queued run, one per cycle unless stalled, into the output register
// ----------------------------------------------------------------------------
module pnfd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  pnfd_pkg::run_t     head,
	input  logic               empty,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         out_char,
	output logic               last_of_run
);
	import pnfd_pkg::*;

	logic [RUN_IW-1:0] idx_q;
	logic              vld_q;
	char_t             char_q;
	logic              last_q;
	logic              load;
	logic              at_last;

	assign load = !vld_q || !out_stall;
	assign at_last = (idx_q == head.last_idx);
	assign pop = load && !empty && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			vld_q <= !empty;
			if (!empty) begin
				idx_q <= at_last ? '0 : idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			char_q <= head.chars[idx_q];
			last_q <= at_last;
		end
	end

	assign out_valid = vld_q;
	assign out_char = char_q;
	assign last_of_run = last_q;

endmodule

[hdl/packed_nucleotide_to_fasta_decoder.sv]
// ----------------------------------------------------------------------------
// packed_nucleotide_to_fasta_decoder
// unpacks 2-bit nucleotide records into fasta text characters
// ----------------------------------------------------------------------------
// channel   signals                                  direction
// in        in_valid, in_stall, in_byte              request in, stall out
// out       out_valid, out_stall, out_char,          request out, stall in
//           last_of_run
// cfg       cfg_wr_en, cfg_wr_data (line_width)      write only
//
// a request is parsed in the cycle it is taken and its run is queued for the output register
// characters leave one per cycle unless stalled: 4 or 5 for a packed byte, up to 8 for one ending a record
// the output serializer sets the rate; a 4-run queue lets input run ahead of it
// reset is asynchronous and clears control state but not stored data; no clearing pass
// ----------------------------------------------------------------------------
module packed_nucleotide_to_fasta_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       last_of_run
);
	import pnfd_pkg::*;

	logic [7:0] line_width_q;
	logic       accept;
	logic       push;
	logic       pop;
	logic       empty;
	logic       full;
	run_t       run;
	run_t       head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RST;
		end else if (cfg_wr_en) begin
			line_width_q <= cfg_wr_data;
		end
	end

	assign in_stall = full;
	assign accept = in_valid && !full;

	pnfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.in_byte    (in_byte),
		.line_width (line_width_q),
		.push       (push),
		.run        (run)
	);

	pnfd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_run (run),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	pnfd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.empty       (empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_char    (out_char),
		.last_of_run (last_of_run)
	);

endmodule

[hdl/pnfd_checker.sv]
// ----------------------------------------------------------------------------
// pnfd_checker
// port level checks of the decoder, bound to the top level
// ----------------------------------------------------------------------------
module pnfd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_char,
	input logic       last_of_run
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(last_of_run))
		else $error("stalled result changed");

	// a run continues without a gap
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_run |=> out_valid)
		else $error("gap inside a run");

	// nothing appears without a request
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && $past(!out_valid) && $past(!(in_valid && !in_stall)) |=> !out_valid)
		else $error("result without request");

	// idle output means the queue has room
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && $past(!out_valid) |-> !in_stall)
		else $error("stall while idle");

endmodule

bind packed_nucleotide_to_fasta_decoder pnfd_checker u_pnfd_checker (.*);

[sim/packed_nucleotide_to_fasta_decoder_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packed_nucleotide_to_fasta_decoder_tb
// streams compressed genome records into the decoder under several line widths
// and idle/stall mixes, and checks every fasta character and its end-of-run
// flag against an in-bench decoder that tracks the same parse state
// ----------------------------------------------------------------------------
module packed_nucleotide_to_fasta_decoder_tb;
	import pnfd_pkg::*;

	typedef enum logic [2:0] {
		AWAIT_FLAG  = 3'd0,
		DESC_LEN    = 3'd1,
		DESC_BYTES  = 3'd2,
		SEQ_LEN     = 3'd3,
		PACKED_DATA = 3'd4
	} parse_t;

	typedef struct packed {
		char_t ch;
		logic last;
	} fasta_char_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [7:0] cfg_wr_data = 8'd0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] in_byte = 8'd0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] out_char;
	logic last_of_run;

	packed_nucleotide_to_fasta_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char(out_char),
		.last_of_run(last_of_run)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	int send_idle_pct = 0;
	int stall_pct = 0;
	logic hold_req = 1'b0;
	logic hold_ack = 1'b0;
	int hold_left = 0;

	logic [7:0] stream_bytes[$];
	fasta_char_t chars_due[$];
	char_t step_chars[$];
	int bytes_queued = 0;
	int requests = 0;
	int chars_seen = 0;
	int records = 0;
	int width_writes = 0;
	int errors = 0;

	// decoder state
	logic [7:0] line_width = LINE_WIDTH_RST;
	parse_t parse_state = AWAIT_FLAG;
	logic rna = 1'b0;
	logic [2:0] field_idx = '0;
	logic [15:0] desc_left = '0;
	logic [63:0] len_acc = '0;
	logic [63:0] nt_left = '0;
	logic [7:0] line_pos = '0;
	logic held_nl = 1'b0;

	// a run holds at most RUN_MAX characters; an extra newline waits for the next request
	function automatic void put_char(char_t c);
		if (step_chars.size() >= RUN_MAX)
			held_nl = 1'b1;
		else
			step_chars.push_back(c);
	endfunction

	function automatic void open_record();
		parse_state = DESC_LEN;
		field_idx = '0;
		len_acc = '0;
		records++;
	endfunction

	function automatic void decode_byte(logic [7:0] b);
		logic [7:0] w;
		logic [1:0] code;
		char_t letter;
		logic done;
		fasta_char_t fc;
		w = (line_width < MIN_WIDTH) ? MIN_WIDTH : line_width;
		done = 1'b0;
		step_chars.delete();
		if (held_nl) begin
			held_nl = 1'b0;
			put_char(CH_NL);
		end
		case (parse_state)
			AWAIT_FLAG: begin
				rna = (b != 8'd0);
				open_record();
			end
			DESC_LEN: begin
				len_acc = len_acc | ({56'd0, b} << (8 * field_idx[0]));
				field_idx = field_idx + 3'd1;
				if (field_idx >= 3'd2) begin
					desc_left = len_acc[15:0];
					field_idx = '0;
					len_acc = '0;
					if (desc_left == 16'd0) begin
						put_char(CH_NL);
						parse_state = SEQ_LEN;
					end else begin
						parse_state = DESC_BYTES;
					end
				end
			end
			DESC_BYTES: begin
				put_char(b);
				desc_left = desc_left - 16'd1;
				if (desc_left == 16'd0) begin
					put_char(CH_NL);
					parse_state = SEQ_LEN;
					field_idx = '0;
					len_acc = '0;
				end
			end
			SEQ_LEN: begin
				len_acc = len_acc | ({56'd0, b} << (8 * field_idx));
				field_idx = field_idx + 3'd1;
				if (field_idx == 3'd0) begin
					nt_left = len_acc;
					line_pos = '0;
					if (nt_left == 64'd0) begin
						put_char(CH_NL);
						put_char(CH_NL);
						open_record();
					end else begin
						parse_state = PACKED_DATA;
					end
				end
			end
			PACKED_DATA: begin
				for (int k = 0; k < 4 && !done; k++) begin
					code = b[(7 - 2 * k) -: 2];
					case (code)
						2'd0: letter = CH_A;
						2'd1: letter = CH_C;
						2'd2: letter = CH_G;
						default: letter = rna ? CH_U : CH_T;
					endcase
					put_char(letter);
					nt_left = nt_left - 64'd1;
					line_pos = line_pos + 8'd1;
					if (line_pos >= w) begin
						put_char(CH_NL);
						line_pos = '0;
					end
					if (nt_left == 64'd0) begin
						if (line_pos != 8'd0)
							put_char(CH_NL);
						line_pos = '0;
						put_char(CH_NL);
						put_char(CH_NL);
						open_record();
						done = 1'b1;
					end
				end
			end
			default: parse_state = AWAIT_FLAG;
		endcase
		for (int i = 0; i < step_chars.size(); i++) begin
			fc.ch = step_chars[i];
			fc.last = (i == step_chars.size() - 1);
			chars_due.push_back(fc);
		end
	endfunction

	// sender
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			decode_byte(in_byte);
			requests++;
		end
		if (!in_valid || !in_stall) begin
			if (stream_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_byte <= stream_bytes.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// long output hold, counted here
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= 400;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// receiver and checker
	always @(posedge clk) begin : check_chars
		fasta_char_t due;
		if (arst_n && out_valid && !out_stall) begin
			chars_seen++;
			if (chars_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected char %h last %0b, nothing expected",
					$time, out_char, last_of_run);
			end else begin
				due = chars_due.pop_front();
				if (out_char !== due.ch) begin
					errors++;
					$display("%0t: out_char expected %h actual %h", $time, due.ch, out_char);
				end
				if (last_of_run !== due.last) begin
					errors++;
					$display("%0t: last_of_run expected %0b actual %0b",
						$time, due.last, last_of_run);
				end
			end
		end
		out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
	end

	task automatic push_byte(logic [7:0] b);
		stream_bytes.push_back(b);
		bytes_queued++;
	endtask

	task automatic push_le(logic [63:0] v, int nbytes);
		for (int i = 0; i < nbytes; i++)
			push_byte(v[8 * i +: 8]);
	endtask

	task automatic push_header(int dlen, logic [63:0] nts);
		push_le(64'(dlen), 2);
		repeat (dlen) push_byte(8'($urandom_range(255)));
		push_le(nts, 8);
	endtask

	task automatic push_random_packed(int nbytes);
		repeat (nbytes) push_byte(8'($urandom_range(255)));
	endtask

	task automatic push_random_record();
		int dlen;
		int nts;
		dlen = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
		case ($urandom_range(9))
			0: nts = 0;
			1: nts = $urandom_range(100, 400);
			default: nts = $urandom_range(1, 40);
		endcase
		push_header(dlen, 64'(nts));
		push_random_packed((nts + 3) / 4);
	endtask

	task automatic drain();
		while (requests != bytes_queued || chars_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_width(logic [7:0] w);
		cfg_wr_data <= w;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		line_width = w;
		width_writes++;
	endtask

	initial begin : stimulus
		logic [7:0] flag;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_width(8'd4);

		// type flag, empty record, then all-T and all-A bytes with padding dropped
		flag = 8'($urandom_range(1, 255));
		if ($urandom_range(1) == 0)
			flag = 8'd0;
		push_byte(flag);
		push_header(0, 64'd0);
		push_header(0, 64'd5);
		push_byte(8'hff);
		push_byte(8'h00);
		drain();

		// line end plus record end in one byte, extra newline carried over
		set_width(8'd6);
		push_header(0, 64'd8);
		push_byte(8'hff);
		push_byte(8'h00);
		push_header(0, 64'd0);
		drain();

		// width lowered in the middle of a line
		set_width(8'd70);
		push_header(0, 64'd40);
		push_random_packed(5);
		drain();
		set_width(8'd5);
		push_random_packed(5);
		drain();

		set_width(8'd255);
		repeat (2) push_random_record();
		drain();

		set_width(8'd0);
		send_idle_pct = 72;
		repeat (2) push_random_record();
		drain();

		set_width(8'd3);
		send_idle_pct = 0;
		stall_pct = 72;
		repeat (2) push_random_record();
		drain();

		set_width(8'($urandom_range(5, 254)));
		send_idle_pct = 11;
		stall_pct = 11;
		repeat (2) push_random_record();
		// stimulus waits for every result before going on
		while (requests != bytes_queued || chars_due.size() != 0)
			@(posedge clk);
		repeat (2) push_random_record();
		drain();

		// output held off while requests keep coming
		set_width(8'd1);
		send_idle_pct = 0;
		stall_pct = 0;
		hold_req <= ~hold_req;
		push_header($urandom_range(0, 4), 64'd200);
		push_random_packed(50);
		repeat (1) push_random_record();
		drain();

		// record that never ends, fed with random bytes
		set_width(8'd70);
		send_idle_pct = 30;
		stall_pct = 30;
		repeat (1) push_random_record();
		push_header($urandom_range(1, 4), {$urandom, $urandom} | 64'h8000_0000_0000_0000);
		push_random_packed(40);
		drain();

		$display("decoded %0d stream bytes into %0d checked characters over %0d records",
			requests, chars_seen, records);
		$display("%0d width writes from 0 to 255, idle and stall mixes, one long output hold",
			width_writes);
		if (errors == 0)
			$display("[packed_nucleotide_to_fasta_decoder] OK");
		else
			$display("[packed_nucleotide_to_fasta_decoder] ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("[packed_nucleotide_to_fasta_decoder] ERROR");
		$finish;
	end

endmodule
